// ===== rtl/bmps_pkg.sv =====
`timescale 1ns / 1ps
package bmps_pkg;

   localparam int LIGHT_WIDTH_DEF  = 128;
   localparam int LIGHT_HEIGHT_DEF = 128;
   localparam int LIGHT_MAX_DEF    = 255;

   localparam int TABLE_DEPTH = 16384;
   localparam int TABLE_AW    = 14;
   localparam int COORD_W     = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PW    = 2;
   localparam int LANES       = 6;
   localparam int RECIP_SHIFT = 14;

   localparam logic [10:0] LIGHT_POS_RESET = 11'd1000;

   localparam logic [15:0] RED_MASK   = 16'hF800;
   localparam logic [15:0] GREEN_MASK = 16'h07E0;
   localparam logic [15:0] BLUE_MASK  = 16'h001F;
   localparam logic [5:0]  RB_MAX     = 6'd31;
   localparam logic [5:0]  G_MAX      = 6'd63;

   localparam logic [5:0] LANE_MAX [LANES] = '{RB_MAX, G_MAX, RB_MAX, RB_MAX, G_MAX, RB_MAX};

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_SHADE = 1'b1
   } bmps_action_type;

   typedef enum logic {
      REG_LIGHT_POS_X = 1'b0,
      REG_LIGHT_POS_Y = 1'b1
   } bmps_reg_type;

   typedef struct packed {
      logic                is_load;
      logic [TABLE_AW-1:0] addr0;
      logic [TABLE_AW-1:0] addr1;
      logic                hit0;
      logic                hit1;
      logic [7:0]          level;
      logic [31:0]         color;
   } bmps_entry_type;

endpackage

// ===== rtl/bmps_if.sv =====
`timescale 1ns / 1ps
interface bmps_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [13:0] table_index;
   logic [7:0]  table_value;
   logic [9:0]  pixel_x;
   logic [9:0]  pixel_y;
   logic [31:0] bump_word;
   logic [31:0] color_word;

   modport source (output valid, action, table_index, table_value, pixel_x, pixel_y,
                   bump_word, color_word, input ready);
   modport sink (input valid, action, table_index, table_value, pixel_x, pixel_y,
                 bump_word, color_word, output ready);
endinterface

interface bmps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] shaded_word;

   modport source (output valid, shaded_word, input ready);
   modport sink (input valid, shaded_word, output ready);
endinterface

interface bmps_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [10:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bmps_front.sv =====
`timescale 1ns / 1ps
module bmps_front #(
   parameter int LIGHT_WIDTH  = bmps_pkg::LIGHT_WIDTH_DEF,
   parameter int LIGHT_HEIGHT = bmps_pkg::LIGHT_HEIGHT_DEF,
   parameter int LIGHT_MAX    = bmps_pkg::LIGHT_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   bmps_req_if.sink                 req_bus,
   bmps_csr_if.sink                 csr_bus,
   output bmps_pkg::bmps_entry_type push_entry,
   output logic                     push_valid,
   input  logic                     push_ready
);

   localparam int CW = bmps_pkg::COORD_W;
   localparam logic signed [CW-1:0] WidthS   = CW'(LIGHT_WIDTH);
   localparam logic signed [CW-1:0] HeightS  = CW'(LIGHT_HEIGHT);
   localparam logic signed [CW-1:0] CentreX  = CW'(LIGHT_WIDTH / 2);
   localparam logic signed [CW-1:0] CentreY  = CW'(LIGHT_HEIGHT / 2);
   localparam logic [8:0]           WidthU   = 9'(LIGHT_WIDTH);
   localparam logic [7:0]           LevelMax = 8'(LIGHT_MAX);

   logic signed [10:0] light_pos_x_ff, light_pos_x_in;
   logic signed [10:0] light_pos_y_ff, light_pos_y_in;

   logic [10:0]                    col1;
   logic signed [CW-1:0]           px0, py0, px1, py1;
   logic                           hit0, hit1;
   logic [bmps_pkg::TABLE_AW-1:0]  addr0, addr1;
   logic [7:0]                     level;

   function automatic logic signed [CW-1:0] offset_coord(
      input logic [10:0]          pix,
      input logic signed [10:0]   pos,
      input logic signed [CW-1:0] centre,
      input logic [7:0]           slope
   );
      return $signed({2'b00, pix}) - $signed({{2{pos[10]}}, pos}) + centre
             + $signed({{5{slope[7]}}, slope});
   endfunction

   function automatic logic [bmps_pkg::TABLE_AW-1:0] table_addr(
      input logic signed [CW-1:0] px,
      input logic signed [CW-1:0] py
   );
      logic [16:0] full;
      full = 17'(py[7:0]) * 17'(WidthU) + 17'(px[7:0]);
      return full[bmps_pkg::TABLE_AW-1:0];
   endfunction

   assign col1 = {1'b0, req_bus.pixel_x} + 11'd1;
   assign px0  = offset_coord({1'b0, req_bus.pixel_x}, light_pos_x_ff, CentreX,
                              req_bus.bump_word[31:24]);
   assign py0  = offset_coord({1'b0, req_bus.pixel_y}, light_pos_y_ff, CentreY,
                              req_bus.bump_word[23:16]);
   assign px1  = offset_coord(col1, light_pos_x_ff, CentreX, req_bus.bump_word[15:8]);
   assign py1  = offset_coord({1'b0, req_bus.pixel_y}, light_pos_y_ff, CentreY,
                              req_bus.bump_word[7:0]);

   assign hit0 = (px0 >= 0) && (px0 < WidthS) && (py0 >= 0) && (py0 < HeightS);
   assign hit1 = (px1 >= 0) && (px1 < WidthS) && (py1 >= 0) && (py1 < HeightS);
   assign addr0 = table_addr(px0, py0);
   assign addr1 = table_addr(px1, py1);
   assign level = (req_bus.table_value > LevelMax) ? LevelMax : req_bus.table_value;

   always_comb begin
      push_entry.is_load = (req_bus.action == bmps_pkg::ACT_LOAD);
      push_entry.level   = level;
      push_entry.color   = req_bus.color_word;
      if (req_bus.action == bmps_pkg::ACT_LOAD) begin
         push_entry.addr0 = req_bus.table_index;
         push_entry.addr1 = req_bus.table_index;
         push_entry.hit0  = 1'b0;
         push_entry.hit1  = 1'b0;
      end else begin
         push_entry.addr0 = addr0;
         push_entry.addr1 = addr1;
         push_entry.hit0  = hit0;
         push_entry.hit1  = hit1;
      end
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      light_pos_x_in = light_pos_x_ff;
      light_pos_y_in = light_pos_y_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bmps_pkg::REG_LIGHT_POS_X: light_pos_x_in = $signed(csr_bus.data);
            bmps_pkg::REG_LIGHT_POS_Y: light_pos_y_in = $signed(csr_bus.data);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_pos_x_ff <= $signed(bmps_pkg::LIGHT_POS_RESET);
         light_pos_y_ff <= $signed(bmps_pkg::LIGHT_POS_RESET);
      end else begin
         light_pos_x_ff <= light_pos_x_in;
         light_pos_y_ff <= light_pos_y_in;
      end
   end

endmodule

// ===== rtl/bmps_queue.sv =====
`timescale 1ns / 1ps
module bmps_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  bmps_pkg::bmps_entry_type push_entry,
   input  logic                     push_valid,
   output logic                     push_ready,
   output bmps_pkg::bmps_entry_type pop_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready
);

   localparam int PW = bmps_pkg::QUEUE_PW;

   bmps_pkg::bmps_entry_type slot_ff [bmps_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != (PW+1)'(bmps_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(bmps_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && count_ff == '0) |=> pop_valid)
      else $error("pushed entry not visible");

endmodule

// ===== rtl/bmps_back.sv =====
`timescale 1ns / 1ps
module bmps_back #(
   parameter int LIGHT_MAX = bmps_pkg::LIGHT_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bmps_pkg::bmps_entry_type pop_entry,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   bmps_rsp_if.source               rsp_bus
);

   localparam int          Half   = LIGHT_MAX / 2;
   localparam logic [7:0]  HalfL  = 8'(Half);
   localparam logic [13:0] HalfP  = 14'(Half);
   localparam logic [9:0]  Recip  = 10'((1 << bmps_pkg::RECIP_SHIFT) / Half);
   localparam int          NL     = bmps_pkg::LANES;

   logic [7:0] mem [bmps_pkg::TABLE_DEPTH];

   logic        adv, pop;
   logic        rd_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic [7:0]  rd0_ff, rd1_ff;
   logic        hit0_ff, hit1_ff;
   logic [31:0] color_ff;

   logic [5:0]  chan_c   [NL];
   logic [7:0]  chan_lvl [NL];
   logic [13:0] prod     [NL];
   logic [5:0]  base     [NL];
   logic [13:0] prod_ff  [NL];
   logic [5:0]  base_ff  [NL];
   logic [23:0] scaled   [NL];
   logic [8:0]  quot_ff  [NL];
   logic [13:0] prod2_ff [NL];
   logic [5:0]  base2_ff [NL];
   logic [13:0] rem      [NL];
   logic [9:0]  quot     [NL];
   logic [9:0]  total    [NL];
   logic [5:0]  chan_out [NL];
   logic [31:0] shaded_in, shaded_ff;
   logic [7:0]  lvl0, lvl1;

   assign adv       = !out_valid_ff || rsp_bus.ready;
   assign pop_ready = adv;
   assign pop       = pop_valid && adv;

   always_ff @(posedge clock) begin
      if (pop && pop_entry.is_load) begin
         mem[pop_entry.addr0] <= pop_entry.level;
      end
      if (adv) begin
         rd0_ff <= mem[pop_entry.addr0];
         rd1_ff <= mem[pop_entry.addr1];
      end
   end

   assign lvl0 = hit0_ff ? rd0_ff : 8'd0;
   assign lvl1 = hit1_ff ? rd1_ff : 8'd0;

   always_comb begin
      chan_c[0]   = 6'((color_ff[15:0] & bmps_pkg::RED_MASK) >> 11);
      chan_c[1]   = 6'((color_ff[15:0] & bmps_pkg::GREEN_MASK) >> 5);
      chan_c[2]   = 6'(color_ff[15:0] & bmps_pkg::BLUE_MASK);
      chan_c[3]   = 6'((color_ff[31:16] & bmps_pkg::RED_MASK) >> 11);
      chan_c[4]   = 6'((color_ff[31:16] & bmps_pkg::GREEN_MASK) >> 5);
      chan_c[5]   = 6'(color_ff[31:16] & bmps_pkg::BLUE_MASK);
      chan_lvl[0] = lvl0;
      chan_lvl[1] = lvl0;
      chan_lvl[2] = lvl0;
      chan_lvl[3] = lvl1;
      chan_lvl[4] = lvl1;
      chan_lvl[5] = lvl1;
      for (int i = 0; i < NL; i++) begin
         if (chan_lvl[i] < HalfL) begin
            prod[i] = 14'(chan_c[i] - (chan_c[i] >> 2)) * 14'(chan_lvl[i]);
            base[i] = chan_c[i] >> 2;
         end else begin
            prod[i] = 14'(bmps_pkg::LANE_MAX[i] - chan_c[i]) * 14'(chan_lvl[i] - HalfL);
            base[i] = chan_c[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         scaled[i] = 24'(prod_ff[i]) * 24'(Recip);
      end
   end

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         rem[i]   = prod2_ff[i] - 14'(14'(quot_ff[i]) * HalfP);
         quot[i]  = (rem[i] >= HalfP) ? 10'(quot_ff[i]) + 10'd1 : 10'(quot_ff[i]);
         total[i] = 10'(base2_ff[i]) + quot[i];
         chan_out[i] = (total[i] > 10'(bmps_pkg::LANE_MAX[i])) ? bmps_pkg::LANE_MAX[i]
                                                                : total[i][5:0];
      end
      shaded_in = {chan_out[3][4:0], chan_out[4], chan_out[5][4:0],
                   chan_out[0][4:0], chan_out[1], chan_out[2][4:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff  <= pop && !pop_entry.is_load;
         s1_valid_ff  <= rd_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit0_ff   <= pop_entry.hit0;
         hit1_ff   <= pop_entry.hit1;
         color_ff  <= pop_entry.color;
         shaded_ff <= shaded_in;
         for (int i = 0; i < NL; i++) begin
            prod_ff[i]  <= prod[i];
            base_ff[i]  <= base[i];
            quot_ff[i]  <= scaled[i][bmps_pkg::RECIP_SHIFT+8:bmps_pkg::RECIP_SHIFT];
            prod2_ff[i] <= prod_ff[i];
            base2_ff[i] <= base_ff[i];
         end
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.shaded_word = shaded_ff;

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.is_load) |=> !rd_valid_ff)
      else $error("load entered the shading pipeline");

   a_shade_enters: assert property (@(posedge clock) disable iff (reset)
      (pop && !pop_entry.is_load) |=> rd_valid_ff)
      else $error("shade entry lost at table read");

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff) |=> out_valid_ff)
      else $error("result lost entering output register");

endmodule

// ===== rtl/bump_map_pixel_shader.sv =====
`timescale 1ns / 1ps
// Channel   Dir   Payload                                                  Transfer
// req_bus   in    action, table_index, table_value, pixel_x, pixel_y,      valid & ready
//                 bump_word, color_word
// rsp_bus   out   shaded_word                                              valid & ready
// csr_bus   in    index (0 light_pos_x, 1 light_pos_y), data               valid & ready
//
// One item per cycle while rsp_bus does not stall; the light table's two read ports and one write port set that rate.
// A shade result passes through the queue, then the table-read, s1, s2 and output registers; loads give no result.
// Reset is synchronous and clears the light position to 1000; the table is not cleared.
// A 4-entry queue separates request intake from the table-read and shading pipeline,
// so a stalled rsp_bus fills the queue before req_bus.ready drops.
module bump_map_pixel_shader #(
   parameter int LIGHT_WIDTH  = bmps_pkg::LIGHT_WIDTH_DEF,
   parameter int LIGHT_HEIGHT = bmps_pkg::LIGHT_HEIGHT_DEF,
   parameter int LIGHT_MAX    = bmps_pkg::LIGHT_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bmps_req_if.sink   req_bus,
   bmps_rsp_if.source rsp_bus,
   bmps_csr_if.sink   csr_bus
);

   bmps_pkg::bmps_entry_type push_entry, pop_entry;
   logic push_valid, push_ready, pop_valid, pop_ready;

   bmps_front #(
      .LIGHT_WIDTH  (LIGHT_WIDTH),
      .LIGHT_HEIGHT (LIGHT_HEIGHT),
      .LIGHT_MAX    (LIGHT_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   bmps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   bmps_back #(
      .LIGHT_MAX (LIGHT_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
